[sv/barometric_flight_event_detector_assert.svh]
// Assertion macros for the flight event detector checker
`ifndef BAROMETRIC_FLIGHT_EVENT_DETECTOR_ASSERT_SVH
`define BAROMETRIC_FLIGHT_EVENT_DETECTOR_ASSERT_SVH

// same-cycle implication, quiet during reset
`define BFED_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("flight event detector check failed");

// next-cycle implication, quiet during reset
`define BFED_ASSERT_NXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("flight event detector check failed");

`endif

[sv/bfed_pkg.sv]
// Types, constants and power table functions for the flight event detector
package bfed_pkg;

	localparam int PRESS_W   = 25;
	localparam int R_BITS    = 18;
	localparam int TAB_W     = 18;
	localparam int LOG_FRAC  = 24;
	localparam longint unsigned EXPONENT_Q24 = 64'd3192704;
	localparam int SCALE_CM  = 4433000;
	localparam logic [R_BITS-1:0] R_SAT = '1;
	localparam logic [PRESS_W-1:0] MIN_INIT = '1;

	localparam logic [5:0]  GROUP_SIZE_RST = 6'd10;
	localparam logic [15:0] CALIB_WIN_RST  = 16'd5000;
	localparam logic [15:0] GROUND_THR_RST = 16'd100;

	// register indexes
	localparam logic [1:0] REG_GROUP_SIZE = 2'd0;
	localparam logic [1:0] REG_CALIB_WIN  = 2'd1;
	localparam logic [1:0] REG_GROUND_THR = 2'd2;

	// request codes
	localparam logic REQ_START  = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	typedef struct packed {
		logic                req_type;
		logic [PRESS_W-1:0]  pressure_q8;
		logic [31:0]         time_ms;
	} req_t;

	typedef struct packed {
		logic signed [23:0]  altitude_cm;
		logic [22:0]         max_altitude_cm;
		logic [31:0]         apogee_time_ms;
		logic                calibrating;
		logic                descending;
		logic                descent_beep;
		logic                landed;
	} res_t;

	typedef struct packed {
		logic [5:0]  group_size;
		logic [15:0] calib_window_ms;
		logic [15:0] ground_threshold_cm;
	} cfg_t;

	typedef enum logic [1:0] {
		PH_READY,
		PH_FLIGHT,
		PH_LANDED
	} phase_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_POS,
		ST_READ,
		ST_INTERP,
		ST_SCALE,
		ST_ALT,
		ST_DECIDE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic div;
		logic pos;
		logic rd;
		logic interp;
		logic scale;
		logic alt;
		logic decide;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic grp_done;
		logic calib;
		logic div_last;
		logic out_free;
	} stat_t;

	// integer square root, bit by bit
	function automatic longint unsigned int_sqrt(longint unsigned v_in);
		longint unsigned v;
		longint unsigned r;
		longint unsigned b;
		v = v_in;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// x in Q2.16, returns x^0.1903 in Q16 via log2 and exp2
	function automatic logic [TAB_W-1:0] pow_q16(longint unsigned x);
		longint unsigned rf [0:LOG_FRAC];
		longint unsigned m;
		longint unsigned frac;
		longint unsigned lb;
		longint unsigned pb;
		longint unsigned fp;
		longint unsigned acc;
		int e;
		int q;
		rf[0] = 64'd1 << 31;
		rf[1] = int_sqrt(64'd1 << 61);
		for (int i = 2; i <= LOG_FRAC; i++)
			rf[i] = int_sqrt(rf[i-1] << 30);
		if (x == 0 || x > (64'd1 << 18))
			return '0;
		e = 0;
		while ((x >> (e + 1)) != 0)
			e++;
		m = x << (30 - e);
		frac = 0;
		for (int k = 0; k < LOG_FRAC; k++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd1 << 31)) begin
				frac = frac | 64'd1;
				m = m >> 1;
			end
		end
		lb = (longint'(e) << LOG_FRAC) + frac;
		pb = ((lb * EXPONENT_Q24) >> LOG_FRAC) + (64'd4 << LOG_FRAC) - 64'd16 * EXPONENT_Q24;
		fp = pb & ((64'd1 << LOG_FRAC) - 1);
		q = int'(pb >> LOG_FRAC);
		if (q > 18)
			q = 18;
		acc = 64'd1 << 30;
		for (int k = 1; k <= LOG_FRAC; k++)
			if (((fp >> (LOG_FRAC - k)) & 64'd1) != 0)
				acc = (acc * rf[k]) >> 30;
		acc = acc >> (18 - q);
		return acc[TAB_W-1:0];
	endfunction

endpackage

[sv/bfed_ctrl.sv]
// Sequencer for the group result computation
module bfed_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  bfed_pkg::stat_t stat,
	output bfed_pkg::cmd_t cmd,
	output logic           req_stall
);
	import bfed_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		req_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					if (stat.grp_done)
						state_d = stat.calib ? ST_OUT : ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				if (stat.div_last)
					state_d = ST_POS;
			end
			ST_POS: begin
				cmd.pos = 1'b1;
				state_d = ST_READ;
			end
			ST_READ: begin
				cmd.rd = 1'b1;
				state_d = ST_INTERP;
			end
			ST_INTERP: begin
				cmd.interp = 1'b1;
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d = ST_ALT;
			end
			ST_ALT: begin
				cmd.alt = 1'b1;
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[sv/bfed_dp.sv]
// Datapath: grouping, ratio division, table interpolation, flight decisions
module bfed_dp #(
	parameter int MAX_GROUP = 63,
	parameter int ENTRIES   = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  bfed_pkg::cfg_t  cfg,
	input  bfed_pkg::req_t  req,
	input  bfed_pkg::cmd_t  cmd,
	output bfed_pkg::stat_t stat,
	input  logic            res_stall,
	output logic            res_valid,
	output bfed_pkg::res_t  res
);
	import bfed_pkg::*;

	localparam int GW    = $clog2(MAX_GROUP + 1);
	localparam int CW    = (GW > 6) ? GW : 6;
	localparam int SUM_W = PRESS_W + GW;
	localparam int IW    = $clog2(ENTRIES + 1);
	localparam int POS_W = R_BITS + IW;
	localparam int DCW   = $clog2(R_BITS);

	typedef logic [TAB_W-1:0] tab_t [0:ENTRIES];

	function automatic tab_t build_tab();
		tab_t t;
		longint unsigned x;
		for (int i = 0; i <= ENTRIES; i++) begin
			x = (longint'(i) << 18) / ENTRIES;
			t[i] = pow_q16(x);
		end
		return t;
	endfunction

	localparam tab_t POW_TAB = build_tab();

	// flight state
	phase_t             phase_q;
	logic [GW-1:0]      cnt_q;
	logic [SUM_W-1:0]   sum_q;
	logic [PRESS_W-1:0] min_q;
	logic [PRESS_W-1:0] max_q;
	logic [SUM_W-1:0]   zref_q;
	logic [31:0]        start_q;
	logic [31:0]        gstart_q;
	logic [22:0]        prev_q;
	logic [22:0]        older_q;
	logic [22:0]        peak_q;
	logic [31:0]        ptime_q;
	logic               desc_q;
	logic               res_valid_q;

	// per-group working registers
	logic [SUM_W-1:0]   trimmed_q;
	logic               calib_q;
	logic               beep_q;
	logic               land_q;
	logic [31:0]        req_time_q;
	logic [SUM_W-1:0]   rem_q;
	logic [R_BITS-1:0]  nb_q;
	logic [R_BITS-1:0]  quo_q;
	logic               sat_q;
	logic [DCW-1:0]     dcnt_q;
	logic [IW-1:0]      idx_q;
	logic [R_BITS-1:0]  fr_q;
	logic [TAB_W-1:0]   t0_q;
	logic [TAB_W-1:0]   t1_q;
	logic signed [TAB_W:0] y_q;
	logic signed [43:0] num_q;
	logic signed [23:0] alt_q;
	res_t               res_q;

	// clamp group size
	logic [CW-1:0] gx;
	logic [GW-1:0] g;
	always_comb begin
		gx = CW'(cfg.group_size);
		if (gx < CW'(4))
			gx = CW'(4);
		if (gx > CW'(MAX_GROUP))
			gx = CW'(MAX_GROUP);
		g = gx[GW-1:0];
	end

	// accumulate the sample and work out the trimmed sum
	logic               is_sample;
	logic               done_c;
	logic [31:0]        gs_c;
	logic [31:0]        gdelta_c;
	logic               calib_c;
	logic [SUM_W-1:0]   sum_n;
	logic [PRESS_W-1:0] min_n;
	logic [PRESS_W-1:0] max_n;
	logic [SUM_W-1:0]   trim_n;
	always_comb begin
		is_sample = (req.req_type == REQ_SAMPLE) && (phase_q == PH_FLIGHT);
		done_c    = is_sample && (cnt_q >= g);
		gs_c      = (cnt_q == '0) ? req.time_ms : gstart_q;
		gdelta_c  = gs_c - start_q;
		calib_c   = (zref_q == '0) || (gdelta_c < {16'd0, cfg.calib_window_ms});
		sum_n     = sum_q + SUM_W'(req.pressure_q8);
		min_n     = (req.pressure_q8 < min_q) ? req.pressure_q8 : min_q;
		max_n     = (req.pressure_q8 > max_q) ? req.pressure_q8 : max_q;
		trim_n    = sum_n - SUM_W'(min_n) - SUM_W'(max_n);
	end

	// one division step
	logic [SUM_W:0] rem2;
	logic           take;
	always_comb begin
		rem2 = {rem_q, nb_q[R_BITS-1]};
		take = (rem2 >= {1'b0, zref_q});
	end

	// ratio to table position
	logic [R_BITS-1:0] r_c;
	logic [POS_W-1:0]  pos_c;
	logic [IW-1:0]     idx_c;
	always_comb begin
		r_c   = sat_q ? R_SAT : quo_q;
		pos_c = POS_W'(r_c) * POS_W'(ENTRIES);
		idx_c = pos_c[POS_W-1:R_BITS];
		if (idx_c >= IW'(ENTRIES))
			idx_c = IW'(ENTRIES - 1);
	end

	// interpolate between neighbouring entries
	logic signed [TAB_W:0] d_c;
	logic [TAB_W-1:0]      ad_c;
	logic [TAB_W+R_BITS-1:0] prod_c;
	logic [TAB_W-1:0]      step_c;
	logic signed [TAB_W:0] y_c;
	always_comb begin
		d_c    = $signed({1'b0, t1_q}) - $signed({1'b0, t0_q});
		ad_c   = d_c[TAB_W] ? TAB_W'(-d_c) : d_c[TAB_W-1:0];
		prod_c = (TAB_W+R_BITS)'(ad_c) * (TAB_W+R_BITS)'(fr_q);
		step_c = prod_c[TAB_W+R_BITS-1:R_BITS];
		y_c    = d_c[TAB_W] ? $signed({1'b0, t0_q}) - $signed({1'b0, step_c})
		                    : $signed({1'b0, t0_q}) + $signed({1'b0, step_c});
	end

	// scale and round toward zero
	logic signed [19:0] diff_c;
	logic signed [43:0] num_c;
	logic signed [43:0] rnd_c;
	always_comb begin
		diff_c = 20'sd65536 - 20'(y_q);
		num_c  = 44'(SCALE_CM) * 44'(diff_c);
		rnd_c  = num_q[43] ? (num_q + 44'sd65535) >>> 16 : num_q >>> 16;
	end

	// flight decisions
	logic signed [23:0] thr_c;
	logic               beep_c;
	logic               desc_c;
	always_comb begin
		thr_c  = $signed({8'd0, cfg.ground_threshold_cm});
		beep_c = (alt_q < $signed({1'b0, prev_q})) && (alt_q < $signed({1'b0, older_q}))
		         && (alt_q > thr_c);
		desc_c = desc_q | beep_c;
	end

	// flight state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_READY;
			cnt_q    <= '0;
			sum_q    <= '0;
			min_q    <= MIN_INIT;
			max_q    <= '0;
			zref_q   <= '0;
			start_q  <= '0;
			gstart_q <= '0;
			prev_q   <= '0;
			older_q  <= '0;
			peak_q   <= '0;
			ptime_q  <= '0;
			desc_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (req.req_type == REQ_START) begin
					if (phase_q == PH_READY) begin
						start_q <= req.time_ms;
						phase_q <= PH_FLIGHT;
					end
				end else if (is_sample) begin
					gstart_q <= gs_c;
					if (!done_c) begin
						cnt_q <= cnt_q + GW'(1);
						sum_q <= sum_n;
						min_q <= min_n;
						max_q <= max_n;
					end else begin
						cnt_q <= '0;
						sum_q <= '0;
						min_q <= MIN_INIT;
						max_q <= '0;
						if (calib_c)
							zref_q <= trim_n;
					end
				end
			end
			if (cmd.decide) begin
				if (alt_q > $signed({1'b0, peak_q})) begin
					peak_q  <= alt_q[22:0];
					ptime_q <= req_time_q;
				end
				desc_q  <= desc_c;
				older_q <= prev_q;
				prev_q  <= alt_q[23] ? '0 : alt_q[22:0];
				if (desc_c && (alt_q < thr_c))
					phase_q <= PH_LANDED;
			end
		end
	end

	// per-group working registers
	always_ff @(posedge clk) begin
		if (cmd.load && done_c) begin
			trimmed_q  <= trim_n;
			calib_q    <= calib_c;
			req_time_q <= req.time_ms;
			beep_q     <= 1'b0;
			land_q     <= 1'b0;
		end
		if (cmd.prep) begin
			sat_q  <= ({2'b00, trimmed_q} >= {zref_q, 2'b00});
			rem_q  <= trimmed_q >> 2;
			nb_q   <= {trimmed_q[1:0], 16'd0};
			quo_q  <= '0;
			dcnt_q <= '0;
		end
		if (cmd.div) begin
			rem_q  <= take ? SUM_W'(rem2 - {1'b0, zref_q}) : rem2[SUM_W-1:0];
			quo_q  <= {quo_q[R_BITS-2:0], take};
			nb_q   <= nb_q << 1;
			dcnt_q <= dcnt_q + DCW'(1);
		end
		if (cmd.pos) begin
			idx_q <= idx_c;
			fr_q  <= pos_c[R_BITS-1:0];
		end
		if (cmd.rd) begin
			t0_q <= POW_TAB[idx_q];
			t1_q <= POW_TAB[idx_q + IW'(1)];
		end
		if (cmd.interp)
			y_q <= y_c;
		if (cmd.scale)
			num_q <= num_c;
		if (cmd.alt)
			alt_q <= rnd_c[23:0];
		if (cmd.decide) begin
			beep_q <= beep_c;
			land_q <= desc_c && (alt_q < thr_c);
		end
		if (cmd.emit) begin
			res_q.altitude_cm     <= calib_q ? 24'sd0 : alt_q;
			res_q.max_altitude_cm <= peak_q;
			res_q.apogee_time_ms  <= ptime_q;
			res_q.calibrating     <= calib_q;
			res_q.descending      <= desc_q;
			res_q.descent_beep    <= beep_q;
			res_q.landed          <= land_q;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (cmd.emit)
			res_valid_q <= 1'b1;
		else if (!res_stall)
			res_valid_q <= 1'b0;
	end

	// status back to the sequencer
	always_comb begin
		stat.grp_done = done_c;
		stat.calib    = calib_c;
		stat.div_last = (dcnt_q == DCW'(R_BITS - 1));
		stat.out_free = !res_valid_q || !res_stall;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

[sv/barometric_flight_event_detector.sv]
// A start event or a sample that does not close a group is taken in the idle state, one
// item per cycle. A calibrating group goes straight to the output state; an altitude group
// first passes the prep, 18-step ratio divider (one quotient bit a cycle), position, read,
// interpolate, scale, altitude and decide states; requests stall until the result is out.
// Reset (arst_n low) clears all flight state and loads the register defaults at once.
// Top level: configuration registers, sequencer and datapath
module barometric_flight_event_detector #(
	parameter int MAX_GROUP           = 63,
	parameter int POWER_TABLE_ENTRIES = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  bfed_pkg::req_t  req,
	output logic            res_valid,
	input  logic            res_stall,
	output bfed_pkg::res_t  res,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [3:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready
);
	import bfed_pkg::*;

	cfg_t  cfg_q;
	cmd_t  cmd;
	stat_t stat;
	logic  wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.group_size          <= GROUP_SIZE_RST;
			cfg_q.calib_window_ms     <= CALIB_WIN_RST;
			cfg_q.ground_threshold_cm <= GROUND_THR_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_GROUP_SIZE: cfg_q.group_size          <= pwdata[5:0];
				REG_CALIB_WIN:  cfg_q.calib_window_ms     <= pwdata[15:0];
				REG_GROUND_THR: cfg_q.ground_threshold_cm <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// register reads
	always_comb begin
		case (paddr[3:2])
			REG_GROUP_SIZE: prdata = {26'd0, cfg_q.group_size};
			REG_CALIB_WIN:  prdata = {16'd0, cfg_q.calib_window_ms};
			REG_GROUND_THR: prdata = {16'd0, cfg_q.ground_threshold_cm};
			default:        prdata = '0;
		endcase
	end

	bfed_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.stat      (stat),
		.cmd       (cmd),
		.req_stall (req_stall)
	);

	bfed_dp #(
		.MAX_GROUP (MAX_GROUP),
		.ENTRIES   (POWER_TABLE_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.res       (res)
	);

endmodule

[sv/bfed_checker.sv]
// Port checker for the flight event detector, bound to the top level
`include "barometric_flight_event_detector_assert.svh"

module bfed_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           res_valid,
	input logic           res_stall,
	input bfed_pkg::res_t res
);
	import bfed_pkg::*;

	`BFED_ASSERT_NXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res))
	`BFED_ASSERT_IMP(a_calib_zero, res_valid && res.calibrating, res.altitude_cm == 24'sd0)
	`BFED_ASSERT_IMP(a_land_desc, res_valid && res.landed, res.descending)
	`BFED_ASSERT_IMP(a_peak_ge, res_valid, $signed({1'b0, res.max_altitude_cm}) >= res.altitude_cm)
	`BFED_ASSERT_NXT(a_land_last, res_valid && !res_stall && res.landed, !res_valid)

endmodule

bind barometric_flight_event_detector bfed_checker u_bfed_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);
